// ===== hw/rtl/assert_macros.svh =====
// ------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions in the checker files.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, muted while reset is held.
`define GWW_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define GWW_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/gww_pkg.sv =====
// ------------------------------------------------------------------------
// gww_pkg
// Types and constants shared by the greedy word wrapper.
// ------------------------------------------------------------------------
package gww_pkg;

    localparam int CHAR_W       = 8;
    localparam int CFG_W        = 6;
    localparam int APB_DW       = 32;
    localparam int PADDR_W      = 3;
    localparam int MAX_LINE_DEF = 32;

    typedef logic [CHAR_W-1:0]    t_char;
    typedef logic [CFG_W-1:0]     t_width_cfg;
    typedef logic [PADDR_W-3:0]   t_reg_idx;

    localparam t_char      SPACE_CHAR     = 8'd32;
    localparam t_width_cfg LINE_WIDTH_RST = 6'd32;
    localparam t_reg_idx   REG_LINE_WIDTH = '0;

    // control broadcast from the sequencer to every buffer cell
    typedef struct packed {
        logic  shift;
        logic  append;
        t_char char_in;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/gww_if.sv =====
// ------------------------------------------------------------------------
// gww_if
// Valid/ready stream interfaces for text bytes in and wrapped bytes out.
// ------------------------------------------------------------------------
interface gww_in_if
    import gww_pkg::*;
();
    logic  valid;
    logic  ready;
    t_char char_in;
    logic  text_last;

    modport source (output valid, output char_in, output text_last, input ready);
    modport sink   (input valid, input char_in, input text_last, output ready);
endinterface

interface gww_out_if
    import gww_pkg::*;
();
    logic  valid;
    logic  ready;
    t_char char_out;
    logic  line_end;
    logic  text_end;
    logic  run_last;

    modport source (output valid, output char_out, output line_end, output text_end,
                    output run_last, input ready);
    modport sink   (input valid, input char_out, input line_end, input text_end,
                    input run_last, output ready);
endinterface

// ===== hw/rtl/greedy_word_wrap_top.sv =====
// ------------------------------------------------------------------------
// greedy_word_wrap_top
// Streaming greedy word wrapper built on a shifting row of byte cells.
// ------------------------------------------------------------------------
//  port     | dir | protocol    | carries
//  i_in     | in  | valid/ready | char_in, text_last
//  o_out    | out | valid/ready | char_out, line_end, text_end, run_last
//  APB      | in  | APB write   | line_width at byte address 0
//
//  A byte is taken only while the sequencer is idle; a byte that completes
//  a line starts a run that emits the line's bytes (EMIT), drops the space
//  the line was broken at, if any (DROP), and re-checks the buffer (EVAL).
//  Emission shifts the whole cell row one slot per cycle unless output stalls.
//  Reset (synchronous) empties the buffer; cell contents are not cleared.
//  A stalled output holds the sequencer; input is taken only between runs.
// ------------------------------------------------------------------------
module greedy_word_wrap_top
    import gww_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    gww_in_if.sink             i_in,
    gww_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int DEPTH = MAX_LINE + 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = $clog2(DEPTH);
    localparam int XW    = (CW > CFG_W) ? CW : CFG_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;
    localparam logic [1:0] S_DROP = 2'd3;

    // configuration
    t_width_cfg    line_width;
    logic [XW-1:0] cfg_x;
    logic [CW-1:0] w_eff;
    logic [CW-1:0] w_plus1;

    gww_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_line_width (line_width)
    );

    assign cfg_x = XW'(line_width);

    always_comb begin
        priority if (cfg_x == '0) begin
            w_eff = CW'(1);
        end else if (cfg_x > XW'(MAX_LINE)) begin
            w_eff = CW'(MAX_LINE);
        end else begin
            w_eff = CW'(cfg_x);
        end
    end

    assign w_plus1 = w_eff + CW'(1);

    // sequencer state
    logic [1:0]    r_state,   n_state;
    logic [CW-1:0] r_count,   n_count;
    logic          r_last,    n_last;
    logic [CW-1:0] r_left,    n_left;
    logic          r_drop,    n_drop;
    logic          r_line_rl, n_line_rl;
    logic          r_line_te, n_line_te;

    // output register
    logic  r_out_valid, n_out_valid;
    t_char r_out_char,  n_out_char;
    logic  r_out_le,    n_out_le;
    logic  r_out_te,    n_out_te;
    logic  r_out_rl,    n_out_rl;

    logic accepting;
    logic out_take;
    logic room;

    assign i_in.ready = (r_state == S_IDLE);
    assign accepting  = i_in.valid && i_in.ready;
    assign out_take   = !r_out_valid || o_out.ready;
    assign room       = (r_count < CW'(DEPTH));

    // cell row
    t_cell_ctl  cell_ctl;
    t_char      cell_byte [DEPTH];
    logic [DEPTH-1:0] cand;

    assign cell_ctl.append  = accepting;
    assign cell_ctl.char_in = i_in.char_in;
    assign cell_ctl.shift   = ((r_state == S_EMIT) && out_take) || (r_state == S_DROP);

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_char nb;
        if (i == DEPTH - 1) begin : g_end
            assign nb = '0;
        end else begin : g_mid
            assign nb = cell_byte[i+1];
        end

        gww_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_count (r_count),
            .i_width (w_eff),
            .i_next  (nb),
            .o_byte  (cell_byte[i]),
            .o_cand  (cand[i])
        );
    end

    logic          sp_found;
    logic [IW-1:0] sp_index;

    gww_find_last #(
        .N (DEPTH)
    ) u_find (
        .i_flags (cand),
        .o_found (sp_found),
        .o_index (sp_index)
    );

    // break decision on the buffer as seen after a pending append
    logic [CW-1:0] cnt_v;
    logic          last_v;
    logic          brk;
    logic          flush;
    logic          drop;
    logic [CW-1:0] len;
    logic [CW-1:0] rem;
    logic          more;

    always_comb begin
        cnt_v  = (accepting && room) ? r_count + CW'(1) : r_count;
        last_v = accepting ? i_in.text_last : r_last;
        brk    = (cnt_v >= w_plus1);
        drop   = brk && sp_found;
        if (brk) begin
            len = sp_found ? CW'(sp_index) : w_eff;
        end else begin
            len = cnt_v;
        end
        flush = !brk && last_v && (cnt_v != '0);
        rem   = cnt_v - len - CW'(drop);
        // another line follows in this run
        more  = (rem >= w_plus1) || (last_v && (rem != '0));
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_last      = r_last;
        n_left      = r_left;
        n_drop      = r_drop;
        n_line_rl   = r_line_rl;
        n_line_te   = r_line_te;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_le    = r_out_le;
        n_out_te    = r_out_te;
        n_out_rl    = r_out_rl;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE, S_EVAL: begin
                if (accepting || (r_state == S_EVAL)) begin
                    if (brk || flush) begin
                        n_state   = S_EMIT;
                        n_count   = cnt_v;
                        n_last    = last_v;
                        n_left    = len;
                        n_drop    = drop;
                        n_line_rl = !more;
                        n_line_te = last_v && !more;
                    end else begin
                        n_state = S_IDLE;
                        n_count = last_v ? '0 : cnt_v;
                        n_last  = 1'b0;
                    end
                end
            end
            S_EMIT: begin
                if (out_take) begin
                    n_out_valid = 1'b1;
                    n_out_char  = cell_byte[0];
                    n_out_le    = (r_left == CW'(1));
                    n_out_te    = (r_left == CW'(1)) && r_line_te;
                    n_out_rl    = (r_left == CW'(1)) && r_line_rl;
                    n_count     = r_count - CW'(1);
                    n_left      = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = r_drop ? S_DROP : S_EVAL;
                    end
                end
            end
            S_DROP: begin
                // discard the space the line was broken at
                n_count = r_count - CW'(1);
                n_state = S_EVAL;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left     <= n_left;
        r_drop     <= n_drop;
        r_line_rl  <= n_line_rl;
        r_line_te  <= n_line_te;
        r_out_char <= n_out_char;
        r_out_le   <= n_out_le;
        r_out_te   <= n_out_te;
        r_out_rl   <= n_out_rl;
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.char_out = r_out_char;
    assign o_out.line_end = r_out_le;
    assign o_out.text_end = r_out_te;
    assign o_out.run_last = r_out_rl;

endmodule

// ===== hw/rtl/gww_cell.sv =====
// ------------------------------------------------------------------------
// gww_cell
// One byte slot of the line buffer: loads on append, takes its upper
// neighbor's byte on shift, and flags itself as a break candidate.
// ------------------------------------------------------------------------
module gww_cell
    import gww_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [CW-1:0] i_count,
    input  logic [CW-1:0] i_width,
    input  t_char         i_next,
    output t_char         o_byte,
    output logic          o_cand
);

    localparam logic [CW-1:0] POS        = CW'(IDX);
    localparam bit            SEARCHABLE = (IDX >= 1);

    t_char r_byte;
    logic  wr_here;
    t_char view;

    assign wr_here = i_ctl.append && (i_count == POS);
    // candidate is judged on the buffer as it stands after this cycle's append
    assign view    = wr_here ? i_ctl.char_in : r_byte;
    assign o_cand  = SEARCHABLE && (POS <= i_width) && (view == SPACE_CHAR);
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_next;
        end else if (wr_here) begin
            r_byte <= i_ctl.char_in;
        end
    end

endmodule

// ===== hw/rtl/gww_find_last.sv =====
// ------------------------------------------------------------------------
// gww_find_last
// Log-depth tree that returns the highest set flag and its position.
// ------------------------------------------------------------------------
module gww_find_last
    import gww_pkg::*;
#(
    parameter  int N  = MAX_LINE_DEF + 1,
    localparam int IW = $clog2(N)
) (
    input  logic [N-1:0]  i_flags,
    output logic          o_found,
    output logic [IW-1:0] o_index
);

    localparam int P = 1 << IW;

    // heap order: node k has children 2k and 2k+1, leaves start at P
    logic          node_f  [1:2*P-1];
    logic [IW-1:0] node_ix [1:2*P-1];

    for (genvar i = 0; i < P; i++) begin : g_leaf
        if (i < N) begin : g_used
            assign node_f[P+i] = i_flags[i];
        end else begin : g_pad
            assign node_f[P+i] = 1'b0;
        end
        assign node_ix[P+i] = IW'(i);
    end

    for (genvar k = 1; k < P; k++) begin : g_node
        assign node_f[k]  = node_f[2*k] | node_f[2*k+1];
        assign node_ix[k] = node_f[2*k+1] ? node_ix[2*k+1] : node_ix[2*k];
    end

    assign o_found = node_f[1];
    assign o_index = node_ix[1];

endmodule

// ===== hw/rtl/gww_cfg.sv =====
// ------------------------------------------------------------------------
// gww_cfg
// APB register file holding the line width setting.
// ------------------------------------------------------------------------
module gww_cfg
    import gww_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    output t_width_cfg         o_line_width
);

    t_width_cfg r_line_width;
    t_reg_idx   reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_LINE_WIDTH);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
        end else if (wr_en) begin
            r_line_width <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        if (reg_idx == REG_LINE_WIDTH) begin
            prdata = APB_DW'(r_line_width);
        end else begin
            prdata = '0;
        end
    end

    assign o_line_width = r_line_width;

endmodule

// ===== hw/rtl/gww_checker.sv =====
// ------------------------------------------------------------------------
// gww_checker
// Port-level checks on the wrapped output stream.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module gww_checker
    import gww_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  i_in_ready,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input t_char i_char_out,
    input logic  i_line_end,
    input logic  i_text_end,
    input logic  i_run_last
);

    localparam int CW = $clog2(MAX_LINE + 1);

    logic [CW-1:0] r_line_len;
    logic          out_acc;
    logic          in_acc;

    assign out_acc = i_out_valid && i_out_ready;
    assign in_acc  = i_in_valid && i_in_ready;

    // bytes already delivered in the current line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len <= '0;
        end else if (out_acc) begin
            r_line_len <= i_line_end ? '0 : r_line_len + CW'(1);
        end
    end

    `GWW_ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")
    `GWW_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_char_out) && $stable(i_line_end) && $stable(i_run_last), "stalled request changed")
    `GWW_ASSERT(a_text_end_marks, i_clk, i_rst_n, i_out_valid && i_text_end |-> i_line_end && i_run_last, "text end off a line end")
    `GWW_ASSERT(a_run_last_on_eol, i_clk, i_rst_n, i_out_valid && i_run_last |-> i_line_end, "run ends inside a line")
    `GWW_ASSERT(a_line_len, i_clk, i_rst_n, i_out_valid || in_acc |-> r_line_len < CW'(MAX_LINE), "line longer than maximum")

endmodule

bind greedy_word_wrap_top gww_checker #(
    .MAX_LINE (MAX_LINE)
) u_gww_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_char_out  (o_out.char_out),
    .i_line_end  (o_out.line_end),
    .i_text_end  (o_out.text_end),
    .i_run_last  (o_out.run_last)
);
